[rtl/cna_pkg.sv]
// Shared widths, operation and status codes, stage types and saturation helpers.
package cna_pkg;

  localparam int W   = 16;        // operand and result width
  localparam int F   = 8;         // fraction bits
  localparam int PW  = 2 * W;     // product and sum-of-products width
  localparam int NW  = PW + F;    // scaled dividend and quotient width
  localparam int SQW = 2 * NW;    // square-root source width, zero padded at the top
  localparam int SRW = W + 4;     // square-root partial remainder width
  localparam int OPW = 3;
  localparam int STW = 2;

  localparam logic [OPW-1:0] OP_ADD  = OPW'(0);
  localparam logic [OPW-1:0] OP_SUB  = OPW'(1);
  localparam logic [OPW-1:0] OP_MUL  = OPW'(2);
  localparam logic [OPW-1:0] OP_DIV  = OPW'(3);
  localparam logic [OPW-1:0] OP_MAG  = OPW'(4);
  localparam logic [OPW-1:0] OP_CONJ = OPW'(5);
  localparam logic [OPW-1:0] OP_EQ   = OPW'(6);

  localparam logic [STW-1:0] ST_OK   = STW'(0);
  localparam logic [STW-1:0] ST_DIVZ = STW'(1);
  localparam logic [STW-1:0] ST_SAT  = STW'(2);

  localparam logic [NW:0] MAXPOS_E = {{(NW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NW:0] MAXNEG_E = {{(NW-W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] RND_HALF = PW'((64'd1 << F) >> 1);

  typedef struct packed {
    logic           vld;
    logic [OPW-1:0] op;
    logic [W-1:0]   pre_re;
    logic [W-1:0]   pre_im;
    logic           pre_flag;
    logic           pre_eq;
    logic           neg_re;
    logic           neg_im;
    logic           zero_div;
    logic [PW-1:0]  den;
    logic [NW-1:0]  num_re;
    logic [NW-1:0]  num_im;
    logic [NW-1:0]  q_re;
    logic [NW-1:0]  q_im;
    logic [PW-1:0]  rem_re;
    logic [PW-1:0]  rem_im;
    logic [SQW-1:0] sq_src;
    logic [SRW-1:0] sq_rem;
    logic [W-1:0]   sq_root;
  } stage_t;

  typedef struct packed {
    logic [W-1:0] val;
    logic         flag;
  } sat_t;

  typedef struct packed {
    logic [W-1:0]   z_re;
    logic [W-1:0]   z_im;
    logic           eq;
    logic [STW-1:0] status;
  } res_t;

  // Clamp a sign and magnitude pair to the signed W-bit range.
  function automatic sat_t sat_mag(input logic neg, input logic [NW:0] mag);
    sat_t r;
    r.flag = 1'b0;
    if (!neg) begin
      if (mag > MAXPOS_E) begin
        r.flag = 1'b1;
        r.val  = MAXPOS_E[W-1:0];
      end else begin
        r.val = mag[W-1:0];
      end
    end else begin
      if (mag > MAXNEG_E) begin
        r.flag = 1'b1;
        r.val  = MAXNEG_E[W-1:0];
      end else begin
        r.val = W'(~mag[W-1:0] + W'(1));
      end
    end
    return r;
  endfunction

  // Magnitude of a signed sum of two products.
  function automatic logic [PW-1:0] abs_sum(input logic [PW:0] s);
    logic [PW:0] m;
    m = s[PW] ? (~s + (PW+1)'(1)) : s;
    return m[PW-1:0];
  endfunction

endpackage

[rtl/cna_front.sv]
// Operand stage: products, simple results, and sums that seed the cell chain.
module cna_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [cna_pkg::OPW-1:0]       in_op,
  input  logic signed [cna_pkg::W-1:0]  x_re,
  input  logic signed [cna_pkg::W-1:0]  x_im,
  input  logic signed [cna_pkg::W-1:0]  y_re,
  input  logic signed [cna_pkg::W-1:0]  y_im,
  output cna_pkg::stage_t               o_stage
);

  logic                          a_vld_r;
  logic [cna_pkg::OPW-1:0]       a_op_r;
  logic [cna_pkg::W-1:0]         a_pre_re_r, a_pre_im_r;
  logic                          a_flag_r, a_eq_r;
  logic signed [cna_pkg::PW-1:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r;
  logic signed [cna_pkg::PW-1:0] p_aa_r, p_bb_r, p_cc_r, p_dd_r;

  logic [cna_pkg::W-1:0] pre_re_nxt, pre_im_nxt;
  logic                  flag_nxt, eq_nxt;
  logic [cna_pkg::W:0]   s_re, s_im;
  cna_pkg::sat_t         sr, si;

  cna_pkg::stage_t stage_r, stage_nxt;

  function automatic cna_pkg::sat_t sat_narrow(input logic [cna_pkg::W:0] s);
    logic [cna_pkg::W:0] m;
    m = s[cna_pkg::W] ? (~s + (cna_pkg::W+1)'(1)) : s;
    return cna_pkg::sat_mag(s[cna_pkg::W], (cna_pkg::NW+1)'(m));
  endfunction

  always_comb begin
    pre_re_nxt = '0;
    pre_im_nxt = '0;
    flag_nxt   = 1'b0;
    eq_nxt     = 1'b0;
    s_re       = '0;
    s_im       = '0;
    case (in_op)
      cna_pkg::OP_ADD: begin
        s_re = {x_re[cna_pkg::W-1], x_re} + {y_re[cna_pkg::W-1], y_re};
        s_im = {x_im[cna_pkg::W-1], x_im} + {y_im[cna_pkg::W-1], y_im};
      end
      cna_pkg::OP_SUB: begin
        s_re = {x_re[cna_pkg::W-1], x_re} - {y_re[cna_pkg::W-1], y_re};
        s_im = {x_im[cna_pkg::W-1], x_im} - {y_im[cna_pkg::W-1], y_im};
      end
      cna_pkg::OP_CONJ: begin
        s_re = {x_re[cna_pkg::W-1], x_re};
        s_im = (cna_pkg::W+1)'(0) - {x_im[cna_pkg::W-1], x_im};
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    sr = sat_narrow(s_re);
    si = sat_narrow(s_im);
    if (in_op == cna_pkg::OP_ADD || in_op == cna_pkg::OP_SUB ||
        in_op == cna_pkg::OP_CONJ) begin
      pre_re_nxt = sr.val;
      pre_im_nxt = si.val;
      flag_nxt   = sr.flag | si.flag;
    end
    if (in_op == cna_pkg::OP_EQ) begin
      eq_nxt = (x_re == y_re) && (x_im == y_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r    <= in_vld;
      a_op_r     <= in_op;
      a_pre_re_r <= pre_re_nxt;
      a_pre_im_r <= pre_im_nxt;
      a_flag_r   <= flag_nxt;
      a_eq_r     <= eq_nxt;
      p_ac_r     <= cna_pkg::PW'(x_re) * cna_pkg::PW'(y_re);
      p_bd_r     <= cna_pkg::PW'(x_im) * cna_pkg::PW'(y_im);
      p_ad_r     <= cna_pkg::PW'(x_re) * cna_pkg::PW'(y_im);
      p_bc_r     <= cna_pkg::PW'(x_im) * cna_pkg::PW'(y_re);
      p_aa_r     <= cna_pkg::PW'(x_re) * cna_pkg::PW'(x_re);
      p_bb_r     <= cna_pkg::PW'(x_im) * cna_pkg::PW'(x_im);
      p_cc_r     <= cna_pkg::PW'(y_re) * cna_pkg::PW'(y_re);
      p_dd_r     <= cna_pkg::PW'(y_im) * cna_pkg::PW'(y_im);
    end
  end

  logic [cna_pkg::PW:0]   s_mr, s_mi, s_dr, s_di;
  logic [cna_pkg::PW-1:0] m_mr, m_mi, m_dr, m_di;
  logic [cna_pkg::PW:0]   r_mr, r_mi;
  cna_pkg::sat_t          sat_mr, sat_mi;

  always_comb begin
    s_mr = {p_ac_r[cna_pkg::PW-1], p_ac_r} - {p_bd_r[cna_pkg::PW-1], p_bd_r};
    s_mi = {p_ad_r[cna_pkg::PW-1], p_ad_r} + {p_bc_r[cna_pkg::PW-1], p_bc_r};
    s_dr = {p_ac_r[cna_pkg::PW-1], p_ac_r} + {p_bd_r[cna_pkg::PW-1], p_bd_r};
    s_di = {p_bc_r[cna_pkg::PW-1], p_bc_r} - {p_ad_r[cna_pkg::PW-1], p_ad_r};
    m_mr = cna_pkg::abs_sum(s_mr);
    m_mi = cna_pkg::abs_sum(s_mi);
    m_dr = cna_pkg::abs_sum(s_dr);
    m_di = cna_pkg::abs_sum(s_di);
    r_mr = ((cna_pkg::PW+1)'(m_mr) + (cna_pkg::PW+1)'(cna_pkg::RND_HALF)) >> cna_pkg::F;
    r_mi = ((cna_pkg::PW+1)'(m_mi) + (cna_pkg::PW+1)'(cna_pkg::RND_HALF)) >> cna_pkg::F;
    sat_mr = cna_pkg::sat_mag(s_mr[cna_pkg::PW], (cna_pkg::NW+1)'(r_mr));
    sat_mi = cna_pkg::sat_mag(s_mi[cna_pkg::PW], (cna_pkg::NW+1)'(r_mi));

    stage_nxt          = '0;
    stage_nxt.vld      = a_vld_r;
    stage_nxt.op       = a_op_r;
    stage_nxt.pre_re   = a_pre_re_r;
    stage_nxt.pre_im   = a_pre_im_r;
    stage_nxt.pre_flag = a_flag_r;
    stage_nxt.pre_eq   = a_eq_r;
    if (a_op_r == cna_pkg::OP_MUL) begin
      stage_nxt.pre_re   = sat_mr.val;
      stage_nxt.pre_im   = sat_mi.val;
      stage_nxt.pre_flag = sat_mr.flag | sat_mi.flag;
    end
    stage_nxt.den      = $unsigned(p_cc_r) + $unsigned(p_dd_r);
    stage_nxt.zero_div = (stage_nxt.den == '0);
    stage_nxt.neg_re   = s_dr[cna_pkg::PW];
    stage_nxt.neg_im   = s_di[cna_pkg::PW];
    stage_nxt.num_re   = cna_pkg::NW'(m_dr) << cna_pkg::F;
    stage_nxt.num_im   = cna_pkg::NW'(m_di) << cna_pkg::F;
    stage_nxt.sq_src   = cna_pkg::SQW'($unsigned(p_aa_r) + $unsigned(p_bb_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign o_stage = stage_r;

endmodule

[rtl/cna_cell.sv]
// One cell of the chain: a quotient bit for each part and a square-root digit.
module cna_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cna_pkg::stage_t i_stage,
  output cna_pkg::stage_t o_stage
);

  cna_pkg::stage_t stage_r, stage_nxt;

  logic [cna_pkg::PW:0]    r2_re, r2_im, den_e;
  logic                    qb_re, qb_im;
  logic [cna_pkg::SRW-1:0] sq_try, sq_t;

  always_comb begin
    stage_nxt = i_stage;
    den_e     = {1'b0, i_stage.den};

    r2_re = {i_stage.rem_re, i_stage.num_re[cna_pkg::NW-1]};
    qb_re = (r2_re >= den_e);
    stage_nxt.rem_re = qb_re ? cna_pkg::PW'(r2_re - den_e) : r2_re[cna_pkg::PW-1:0];
    stage_nxt.q_re   = {i_stage.q_re[cna_pkg::NW-2:0], qb_re};
    stage_nxt.num_re = {i_stage.num_re[cna_pkg::NW-2:0], 1'b0};

    r2_im = {i_stage.rem_im, i_stage.num_im[cna_pkg::NW-1]};
    qb_im = (r2_im >= den_e);
    stage_nxt.rem_im = qb_im ? cna_pkg::PW'(r2_im - den_e) : r2_im[cna_pkg::PW-1:0];
    stage_nxt.q_im   = {i_stage.q_im[cna_pkg::NW-2:0], qb_im};
    stage_nxt.num_im = {i_stage.num_im[cna_pkg::NW-2:0], 1'b0};

    sq_try = {i_stage.sq_rem[cna_pkg::SRW-3:0],
              i_stage.sq_src[cna_pkg::SQW-1 -: 2]};
    sq_t   = {2'b00, i_stage.sq_root, 2'b01};
    if (sq_try >= sq_t) begin
      stage_nxt.sq_rem  = sq_try - sq_t;
      stage_nxt.sq_root = {i_stage.sq_root[cna_pkg::W-2:0], 1'b1};
    end else begin
      stage_nxt.sq_rem  = sq_try;
      stage_nxt.sq_root = {i_stage.sq_root[cna_pkg::W-2:0], 1'b0};
    end
    stage_nxt.sq_src = {i_stage.sq_src[cna_pkg::SQW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign o_stage = stage_r;

endmodule

[rtl/cna_back.sv]
// Final rounding, saturation and result selection at the end of the chain.
module cna_back (
  input  cna_pkg::stage_t i_stage,
  output cna_pkg::res_t   o_res
);

  logic [cna_pkg::NW:0] qr_re, qr_im, root_e;
  cna_pkg::sat_t        sd_re, sd_im, s_mag;

  always_comb begin
    qr_re  = {1'b0, i_stage.q_re} +
             (cna_pkg::NW+1)'(i_stage.rem_re >= (i_stage.den - i_stage.rem_re));
    qr_im  = {1'b0, i_stage.q_im} +
             (cna_pkg::NW+1)'(i_stage.rem_im >= (i_stage.den - i_stage.rem_im));
    root_e = (cna_pkg::NW+1)'(i_stage.sq_root) +
             (cna_pkg::NW+1)'(i_stage.sq_rem > cna_pkg::SRW'(i_stage.sq_root));
    sd_re  = cna_pkg::sat_mag(i_stage.neg_re, qr_re);
    sd_im  = cna_pkg::sat_mag(i_stage.neg_im, qr_im);
    s_mag  = cna_pkg::sat_mag(1'b0, root_e);

    o_res = '0;
    unique case (i_stage.op)
      cna_pkg::OP_ADD, cna_pkg::OP_SUB, cna_pkg::OP_MUL, cna_pkg::OP_CONJ: begin
        o_res.z_re   = i_stage.pre_re;
        o_res.z_im   = i_stage.pre_im;
        o_res.status = i_stage.pre_flag ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
      end
      cna_pkg::OP_DIV: begin
        if (i_stage.zero_div) begin
          o_res.status = cna_pkg::ST_DIVZ;
        end else begin
          o_res.z_re   = sd_re.val;
          o_res.z_im   = sd_im.val;
          o_res.status = (sd_re.flag | sd_im.flag) ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
        end
      end
      cna_pkg::OP_MAG: begin
        o_res.z_re   = s_mag.val;
        o_res.status = s_mag.flag ? cna_pkg::ST_SAT : cna_pkg::ST_OK;
      end
      cna_pkg::OP_EQ: begin
        o_res.eq = i_stage.pre_eq;
      end
      default: begin
        o_res = '0;
      end
    endcase
  end

endmodule

[rtl/complex_number_alu.sv]
// Top level of the complex-number arithmetic unit: front stage, cell chain and output register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | operation, x_real, x_imag, y_real, y_imag
//   out_    | output    | out_valid / out_stall | z_real, z_imag, is_equal, status
//
// The unit takes one item in every cycle while in_stall is low and returns one result per item.
// Operands are Q8.8. The path holds two front stages for the products and their
// sums, one cell per quotient bit in the chain, and the output register.
// The chain length is set by the divide: each cell settles one quotient bit of both
// parts and, on the same pass, one square-root digit for the magnitude.
// Reset clears the valid bits of every stage and of the output register only.
// The whole pipeline advances together whenever the output register is empty or is
// being taken; a stalled result holds every stage, so in_stall is high only then.
module complex_number_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cna_pkg::OPW-1:0]       in_operation,
  input  logic signed [cna_pkg::W-1:0]  in_x_real,
  input  logic signed [cna_pkg::W-1:0]  in_x_imag,
  input  logic signed [cna_pkg::W-1:0]  in_y_real,
  input  logic signed [cna_pkg::W-1:0]  in_y_imag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [cna_pkg::W-1:0]  out_z_real,
  output logic signed [cna_pkg::W-1:0]  out_z_imag,
  output logic                          out_is_equal,
  output logic [cna_pkg::STW-1:0]       out_status
);

  // The pipeline moves when the output register is free or its item leaves this cycle.
  logic adv;
  logic out_valid_r;
  cna_pkg::res_t res_r, res_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage zero comes from the front; each cell hands its stage to the next one.
  cna_pkg::stage_t chain [0:cna_pkg::NW];

  cna_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_op   (in_operation),
    .x_re    (in_x_real),
    .x_im    (in_x_imag),
    .y_re    (in_y_real),
    .y_im    (in_y_imag),
    .o_stage (chain[0])
  );

  for (genvar g = 0; g < cna_pkg::NW; g++) begin : g_cell
    cna_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .i_stage (chain[g]),
      .o_stage (chain[g+1])
    );
  end

  // Rounding of the quotients and the root, then the per-operation result pick.
  cna_back u_back (
    .i_stage (chain[cna_pkg::NW]),
    .o_res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[cna_pkg::NW].vld;
      res_r       <= res_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_z_real   = res_r.z_re;
  assign out_z_imag   = res_r.z_im;
  assign out_is_equal = res_r.eq;
  assign out_status   = res_r.status;

  // A divide by zero always returns a zero result.
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cna_pkg::ST_DIVZ |-> out_z_real == '0 && out_z_imag == '0)
    else $error("divide by zero returned a nonzero result");

  // An equal answer carries no number and no error.
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_equal |-> out_status == cna_pkg::ST_OK && out_z_real == '0 &&
    out_z_imag == '0)
    else $error("equal result carries data or status");

  // The input side is held back only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  // A result that was stalled is still offered in the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("stalled result changed");

endmodule
